FILE: rtl/csfw_pkg.sv
// Shared types, codes and constants for the counting semaphore block.
`timescale 1ns / 1ps
package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam int CMD_W     = 2;
  localparam int ID_W      = 8;   // thread id field width on the ports
  localparam int ID_EXT_W  = 16;  // widest thread id the block can store
  localparam int EVENT_W   = 3;
  localparam int INIT_W    = 16;
  localparam int COUNT_W   = 18;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WAIT   = 2'd0,
    CMD_SIGNAL = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_PASSED     = 3'd0,
    EV_BLOCKED    = 3'd1,
    EV_RELEASED   = 3'd2,
    EV_NO_WAITER  = 3'd3,
    EV_CLOSE_DONE = 3'd4,
    EV_QUEUE_FULL = 3'd5
  } event_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  thread_id;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [ID_W-1:0]    released_id;
    logic               wait_failed;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the caller's thread id
    logic do_wait;
    logic do_signal;
    logic do_pop;     // release one waiter during close
    logic do_done;    // report close completion
  } csfw_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic q_empty;
  } csfw_stat_t;

endpackage

FILE: rtl/csfw_ctrl.sv
// Controller state machine: sequences wait, signal and close commands.
`timescale 1ns / 1ps
module csfw_ctrl
  import csfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_item_t   in_item,
  input  csfw_stat_t stat,
  output logic       busy,
  output csfw_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SIGNAL,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r,  busy_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.latch = 1'b1;
          case (cmd_t'(in_item.command))
            CMD_WAIT:   state_nxt = ST_WAIT;
            CMD_SIGNAL: state_nxt = ST_SIGNAL;
            CMD_CLOSE:  state_nxt = ST_DRAIN;
            default:    state_nxt = ST_IDLE;  // unused code, dropped
          endcase
        end
      end
      ST_WAIT: begin
        ctrl.do_wait = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_SIGNAL: begin
        ctrl.do_signal = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_DRAIN: begin
        if (stat.q_empty) begin
          ctrl.do_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          ctrl.do_pop = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

FILE: rtl/csfw_dp.sv
// Datapath: count, waiter queue memory with pointers, result register.
`timescale 1ns / 1ps
module csfw_dp
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  logic              cfg_we,
  input  logic [INIT_W-1:0] cfg_data,
  input  csfw_ctrl_t        ctrl,
  output csfw_stat_t        stat,
  output logic              out_valid,
  output out_item_t         out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]          head_r,  head_nxt;
  logic [PTR_W-1:0]          tail_r,  tail_nxt;
  logic [OCC_W-1:0]          occ_r,   occ_nxt;
  logic [THREAD_ID_BITS-1:0] tid_r,   tid_nxt;
  logic [THREAD_ID_BITS-1:0] rd_r;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_r,       out_nxt;

  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic                      mem_we;
  logic [PTR_W-1:0]          rd_addr;
  logic                      pop;
  logic signed [COUNT_W-1:0] count_inc;
  logic [ID_EXT_W-1:0]       tid_ext;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign tid_ext   = ID_EXT_W'(in_item.thread_id);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

  always_comb begin
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    tid_nxt       = tid_r;
    mem_we        = 1'b0;
    pop           = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;

    if (ctrl.latch) begin
      tid_nxt = tid_ext[THREAD_ID_BITS-1:0];
    end

    if (ctrl.do_wait) begin
      out_valid_nxt = 1'b1;
      if (count_r > 0) begin
        count_nxt         = count_r - COUNT_W'(1);
        out_nxt.event_res = EV_PASSED;
      end else if (occ_r == OCC_FULL) begin
        out_nxt.event_res = EV_QUEUE_FULL;
      end else begin
        if (count_r != COUNT_MIN) begin
          count_nxt = count_r - COUNT_W'(1);
        end
        mem_we            = 1'b1;
        tail_nxt          = ptr_inc(tail_r);
        occ_nxt           = occ_r + OCC_W'(1);
        out_nxt.event_res = EV_BLOCKED;
      end
    end

    if (ctrl.do_signal) begin
      out_valid_nxt = 1'b1;
      count_nxt     = count_inc;
      if (count_inc > 0) begin
        out_nxt.event_res = EV_PASSED;
      end else if (occ_r == '0) begin
        out_nxt.event_res = EV_NO_WAITER;
      end else begin
        pop                 = 1'b1;
        out_nxt.event_res   = EV_RELEASED;
        out_nxt.released_id = ID_W'(rd_r);
      end
    end

    if (ctrl.do_pop) begin
      pop                 = 1'b1;
      out_valid_nxt       = 1'b1;
      out_nxt.event_res   = EV_RELEASED;
      out_nxt.released_id = ID_W'(rd_r);
      out_nxt.wait_failed = 1'b1;
      out_nxt.last        = 1'b0;
    end

    if (ctrl.do_done) begin
      out_valid_nxt     = 1'b1;
      out_nxt.event_res = EV_CLOSE_DONE;
    end

    if (pop) begin
      head_nxt = ptr_inc(head_r);
      occ_nxt  = occ_r - OCC_W'(1);
    end

    // re-create: new count, queue emptied
    if (cfg_we) begin
      count_nxt = COUNT_W'(cfg_data);
      head_nxt  = '0;
      tail_nxt  = '0;
      occ_nxt   = '0;
    end
  end

  // read the entry that will be at the head after this cycle
  assign rd_addr = pop ? ptr_inc(head_r) : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= tid_r;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RST;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tid_r <= tid_nxt;
    out_r <= out_nxt;
  end

  assign stat.q_empty = (occ_r == '0);
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

FILE: rtl/counting_semaphore_fifo_wait.sv
// Top level of the counting semaphore with a FIFO queue of blocked threads.
`timescale 1ns / 1ps
// Usage:
//   Command channel: a command transfers at a rising edge with start high and
//   busy low. in_item carries the command (wait, signal, close) and the
//   caller's thread id. Command code 3 is taken and dropped without a result.
//   Result channel: each result sits on out_item for one cycle with out_valid
//   high; the receiver cannot stall it. out_item.last marks a command's final
//   result.
//   Configuration: cfg_we with cfg_data loads a new initial count and empties
//   the waiter queue; write only while idle. No result is produced.
// Timing:
//   Wait and signal: the result is registered from the controller's execute
//   state; busy stays high until the controller is back in idle, so a new
//   command is taken only after the last one is done. Close with N waiters
//   queued: N releases on consecutive cycles, then close done. The waiter
//   queue memory has a registered read port (one pop per cycle).
// Reset: synchronous, active low. Count returns to 1, the queue empties,
//   the controller idles. Queue contents are left as they are.
module counting_semaphore_fifo_wait
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  input  logic              cfg_we,
  input  logic [INIT_W-1:0] cfg_data,
  output logic              out_valid,
  output out_item_t         out_item
);

  csfw_ctrl_t ctrl;
  csfw_stat_t stat;

  // sequencing: idle, execute wait/signal, drain on close
  csfw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  // count arithmetic, waiter queue and the result register
  csfw_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // a close keeps releasing every cycle until its final result
  a_drain_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("close drain broke off before its final result");

  // an accepted wait or signal is answered by a final result
  a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.command == CMD_WAIT || in_item.command == CMD_SIGNAL)
    |-> ##2 (out_valid && out_item.last))
    else $error("wait/signal result missing or late");

  // a failed wait only comes from a close release, never the final transfer
  a_failed_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.wait_failed |-> out_item.event_res == EV_RELEASED && !out_item.last)
    else $error("failed wait flagged on a non-release result");

endmodule
